// ===== sv/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared widths, register indexes and reset values for the landmark
// smoothing and distance block.
// ----------------------------------------------------------------------------
package lsd_pkg;

    localparam int COORD_W    = 17;
    localparam int DIM_W      = 13;
    localparam int GAIN_W     = 17;
    localparam int RAD_W      = 16;
    localparam int PIX_W      = 13;
    localparam int AVG_W      = 21;
    localparam int GAP_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int CNT_W      = 5;

    localparam int MAX_FRAME_DIM_DEF = 4096;

    // unit in Q1.16
    localparam logic [COORD_W-1:0] Q16_ONE = COORD_W'(65536);

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = DIM_W'(480);
    localparam logic [GAIN_W-1:0] RST_GAIN         = GAIN_W'(39322);
    localparam logic [RAD_W-1:0]  RST_RADIUS       = '0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd3;

    // action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // last step indexes of the serial phases
    localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(DIM_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(17);
    localparam logic [CNT_W-1:0] ROOT_LAST  = CNT_W'(18);

endpackage

// ===== sv/lsd_sermul.sv =====
// ----------------------------------------------------------------------------
// lsd_sermul
// Bit-serial multiplier: signed multiplicand, unsigned multiplier taken one
// bit per cycle while i_step is high, most significant bit first.
// ----------------------------------------------------------------------------
module lsd_sermul #(
    parameter int A_W = 18,
    parameter int B_W = 13
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_step,
    input  logic signed [A_W-1:0]     i_a,
    input  logic [B_W-1:0]            i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    localparam int P_W = A_W + B_W;

    logic signed [A_W-1:0] r_a;
    logic [B_W-1:0]        r_b;
    logic [P_W-1:0]        r_acc;
    logic [P_W-1:0]        w_add;

    assign w_add = r_b[B_W-1] ? {{B_W{r_a[A_W-1]}}, r_a} : '0;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_step) begin
            r_b   <= {r_b[B_W-2:0], 1'b0};
            r_acc <= {r_acc[P_W-2:0], 1'b0} + w_add;
        end
    end

    assign o_p = $signed(r_acc);

endmodule

// ===== sv/lsd_isqrt.sv =====
// ----------------------------------------------------------------------------
// lsd_isqrt
// Serial integer square root, floor, one root bit per cycle while i_step is high.
// ----------------------------------------------------------------------------
module lsd_isqrt #(
    parameter int V_W = 36
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_step,
    input  logic [V_W-1:0]     i_v,
    output logic [V_W/2-1:0]   o_root
);

    localparam int R_W = V_W / 2;

    logic [V_W-1:0] r_v;
    logic [R_W:0]   r_rem;
    logic [R_W-1:0] r_root;
    logic [R_W+2:0] w_rem_sh;
    logic [R_W+2:0] w_trial;
    logic           w_fit;

    // bring down the next two bits and try root*4+1
    assign w_rem_sh = {r_rem, r_v[V_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_v    <= i_v;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_step) begin
            r_v    <= {r_v[V_W-3:0], 2'b00};
            r_rem  <= w_fit ? (R_W+1)'(w_rem_sh - w_trial) : (R_W+1)'(w_rem_sh);
            r_root <= {r_root[R_W-2:0], w_fit};
        end
    end

    assign o_root = r_root;

endmodule

// ===== sv/landmark_smoothing_and_distance.sv =====
// ----------------------------------------------------------------------------
// landmark_smoothing_and_distance
// Scales four fingertip points to pixels, flags small middle-tip moves,
// smooths the middle tip and measures thumb-index and thumb-pinky gaps.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  config  | i_cfg_we                   | i_cfg_index, i_cfg_data
//  sample  | i_in_valid / o_in_stall    | i_action, i_thumb_x .. i_pinky_y
//  result  | o_out_valid / i_out_stall  | o_thumb_index_gap .. o_filtered_y
//
// a sample beat runs from acceptance through bit-serial pixel scaling, serial
// squaring and blending, the bit-serial square root and a hand-off state into
// the output register; the next beat is taken in the idle state after that.
// a clear beat is taken in the idle state and gives no result.
// synchronous active-low reset restores the register defaults and history.
// a waiting result holds the block in hand-off; the next beat is taken once
// the result has moved to the output register.
// ----------------------------------------------------------------------------
module landmark_smoothing_and_distance #(
    parameter int MAX_FRAME_DIM = lsd_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [lsd_pkg::COORD_W-1:0]       i_thumb_x,
    input  logic [lsd_pkg::COORD_W-1:0]       i_thumb_y,
    input  logic [lsd_pkg::COORD_W-1:0]       i_index_x,
    input  logic [lsd_pkg::COORD_W-1:0]       i_index_y,
    input  logic [lsd_pkg::COORD_W-1:0]       i_middle_x,
    input  logic [lsd_pkg::COORD_W-1:0]       i_middle_y,
    input  logic [lsd_pkg::COORD_W-1:0]       i_pinky_x,
    input  logic [lsd_pkg::COORD_W-1:0]       i_pinky_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lsd_pkg::GAP_W-1:0]         o_thumb_index_gap,
    output logic [lsd_pkg::GAP_W-1:0]         o_thumb_pinky_gap,
    output logic                              o_in_dead_zone,
    output logic [lsd_pkg::AVG_W-1:0]         o_filtered_x,
    output logic [lsd_pkg::AVG_W-1:0]         o_filtered_y
);

    localparam int CW  = lsd_pkg::COORD_W;
    localparam int DW  = lsd_pkg::DIM_W;
    localparam int PW  = lsd_pkg::PIX_W;
    localparam int AW  = lsd_pkg::AVG_W;
    localparam int GW  = lsd_pkg::GAIN_W;
    localparam int RW  = lsd_pkg::RAD_W;
    localparam int SQ_A = PW + 1;
    localparam int SQ_P = SQ_A + 17;
    localparam int BL_A = AW + 1;
    localparam int BL_P = BL_A + GW;
    localparam int RR_P = 2 * (RW + 1);
    localparam int SC_P = CW + 1 + DW;
    localparam int V_W  = 36;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_MUL,
        ST_ROOT,
        ST_HOLD
    } t_state;

    // configuration
    logic [DW-1:0] r_frame_width;
    logic [DW-1:0] r_frame_height;
    logic [GW-1:0] r_gain;
    logic [RW-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lsd_pkg::RST_FRAME_WIDTH;
            r_frame_height <= lsd_pkg::RST_FRAME_HEIGHT;
            r_gain         <= lsd_pkg::RST_GAIN;
            r_radius       <= lsd_pkg::RST_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lsd_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DW-1:0];
                lsd_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DW-1:0];
                lsd_pkg::REG_GAIN:         r_gain         <= i_cfg_data[GW-1:0];
                lsd_pkg::REG_RADIUS:       r_radius       <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // control and history
    t_state                    r_state;
    logic [lsd_pkg::CNT_W-1:0] r_cnt;
    logic                      r_hist;
    logic [PW-1:0]             r_last_x;
    logic [PW-1:0]             r_last_y;
    logic [AW-1:0]             r_avg_x;
    logic [AW-1:0]             r_avg_y;
    logic                      r_dead;
    logic                      r_out_valid;
    logic [lsd_pkg::GAP_W-1:0] r_gap_ti;
    logic [lsd_pkg::GAP_W-1:0] r_gap_tp;
    logic                      r_out_dead;
    logic [AW-1:0]             r_out_x;
    logic [AW-1:0]             r_out_y;

    logic w_accept;
    logic w_out_free;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // clamped frame size and gain
    logic [DW-1:0] w_dim_w;
    logic [DW-1:0] w_dim_h;
    logic [GW-1:0] w_gain;

    always_comb begin
        if (r_frame_width == '0) begin
            w_dim_w = DW'(1);
        end else if (32'(r_frame_width) > MAX_FRAME_DIM) begin
            w_dim_w = DW'(MAX_FRAME_DIM);
        end else begin
            w_dim_w = r_frame_width;
        end
        if (r_frame_height == '0) begin
            w_dim_h = DW'(1);
        end else if (32'(r_frame_height) > MAX_FRAME_DIM) begin
            w_dim_h = DW'(MAX_FRAME_DIM);
        end else begin
            w_dim_h = r_frame_height;
        end
        w_gain = (r_gain > lsd_pkg::Q16_ONE) ? lsd_pkg::Q16_ONE : r_gain;
    end

    // pixel scaling lanes: thumb, index, middle, pinky, x then y
    logic [CW-1:0]          w_coord [8];
    logic [PW-1:0]          w_pix   [8];
    logic signed [SC_P-1:0] w_sc_p  [8];

    assign w_coord[0] = i_thumb_x;
    assign w_coord[1] = i_thumb_y;
    assign w_coord[2] = i_index_x;
    assign w_coord[3] = i_index_y;
    assign w_coord[4] = i_middle_x;
    assign w_coord[5] = i_middle_y;
    assign w_coord[6] = i_pinky_x;
    assign w_coord[7] = i_pinky_y;

    logic w_sc_step;
    assign w_sc_step = (r_state == ST_SCALE);

    for (genvar gi = 0; gi < 8; gi++) begin : g_scale
        logic [CW-1:0] w_clamped;
        assign w_clamped = (w_coord[gi] > lsd_pkg::Q16_ONE) ? lsd_pkg::Q16_ONE
                                                             : w_coord[gi];
        lsd_sermul #(
            .A_W (CW + 1),
            .B_W (DW)
        ) u_scale (
            .i_clk  (i_clk),
            .i_load (w_accept),
            .i_step (w_sc_step),
            .i_a    ($signed({1'b0, w_clamped})),
            .i_b    ((gi % 2 == 0) ? w_dim_w : w_dim_h),
            .o_p    (w_sc_p[gi])
        );
        assign w_pix[gi] = w_sc_p[gi][PW+15:16];
    end

    // absolute differences for the three squared distances
    function automatic logic [PW-1:0] f_absdiff(input logic [PW-1:0] a,
                                                input logic [PW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [PW-1:0] w_diff [6];
    assign w_diff[0] = f_absdiff(w_pix[0], w_pix[2]);
    assign w_diff[1] = f_absdiff(w_pix[1], w_pix[3]);
    assign w_diff[2] = f_absdiff(w_pix[0], w_pix[6]);
    assign w_diff[3] = f_absdiff(w_pix[1], w_pix[7]);
    assign w_diff[4] = f_absdiff(w_pix[4], r_last_x);
    assign w_diff[5] = f_absdiff(w_pix[5], r_last_y);

    logic w_mul_load;
    logic w_mul_step;
    assign w_mul_load = (r_state == ST_MUL) && (r_cnt == '0);
    assign w_mul_step = (r_state == ST_MUL) && (r_cnt != '0);

    logic signed [SQ_P-1:0] w_sq_p [6];

    for (genvar gi = 0; gi < 6; gi++) begin : g_square
        lsd_sermul #(
            .A_W (SQ_A),
            .B_W (17)
        ) u_square (
            .i_clk  (i_clk),
            .i_load (w_mul_load),
            .i_step (w_mul_step),
            .i_a    ($signed({1'b0, w_diff[gi]})),
            .i_b    ({4'b0000, w_diff[gi]}),
            .o_p    (w_sq_p[gi])
        );
    end

    // radius squared
    logic signed [RR_P-1:0] w_rr_p;

    lsd_sermul #(
        .A_W (RW + 1),
        .B_W (RW + 1)
    ) u_radius_sq (
        .i_clk  (i_clk),
        .i_load (w_mul_load),
        .i_step (w_mul_step),
        .i_a    ($signed({1'b0, r_radius})),
        .i_b    ({1'b0, r_radius}),
        .o_p    (w_rr_p)
    );

    // blend as prev + floor(g * (cur - prev) / 65536)
    logic signed [BL_A-1:0] w_dx_avg;
    logic signed [BL_A-1:0] w_dy_avg;
    logic signed [BL_P-1:0] w_bx_p;
    logic signed [BL_P-1:0] w_by_p;

    assign w_dx_avg = $signed({1'b0, w_pix[4], 8'h00}) - $signed({1'b0, r_avg_x});
    assign w_dy_avg = $signed({1'b0, w_pix[5], 8'h00}) - $signed({1'b0, r_avg_y});

    lsd_sermul #(
        .A_W (BL_A),
        .B_W (GW)
    ) u_blend_x (
        .i_clk  (i_clk),
        .i_load (w_mul_load),
        .i_step (w_mul_step),
        .i_a    (w_dx_avg),
        .i_b    (w_gain),
        .o_p    (w_bx_p)
    );

    lsd_sermul #(
        .A_W (BL_A),
        .B_W (GW)
    ) u_blend_y (
        .i_clk  (i_clk),
        .i_load (w_mul_load),
        .i_step (w_mul_step),
        .i_a    (w_dy_avg),
        .i_b    (w_gain),
        .o_p    (w_by_p)
    );

    logic [BL_P-17:0] w_new_x;
    logic [BL_P-17:0] w_new_y;
    assign w_new_x = (BL_P-16)'({2'b00, r_avg_x}) + w_bx_p[BL_P-1:16];
    assign w_new_y = (BL_P-16)'({2'b00, r_avg_y}) + w_by_p[BL_P-1:16];

    // sums of squares and dead-zone compare
    logic [2*PW:0] w_d2_ti;
    logic [2*PW:0] w_d2_tp;
    logic [2*PW:0] w_d2_m;
    logic          w_small_move;

    assign w_d2_ti = {1'b0, w_sq_p[0][2*PW-1:0]} + {1'b0, w_sq_p[1][2*PW-1:0]};
    assign w_d2_tp = {1'b0, w_sq_p[2][2*PW-1:0]} + {1'b0, w_sq_p[3][2*PW-1:0]};
    assign w_d2_m  = {1'b0, w_sq_p[4][2*PW-1:0]} + {1'b0, w_sq_p[5][2*PW-1:0]};
    assign w_small_move = {w_d2_m, 8'h00} < (2*PW+9)'(w_rr_p[2*RW-1:0]);

    // square roots of the two gaps, taken of the sums scaled by 256 for Q.4
    logic                w_root_load;
    logic                w_root_step;
    logic [V_W/2-1:0]    w_root_ti;
    logic [V_W/2-1:0]    w_root_tp;

    assign w_root_load = (r_state == ST_ROOT) && (r_cnt == '0);
    assign w_root_step = (r_state == ST_ROOT) && (r_cnt != '0);

    lsd_isqrt #(
        .V_W (V_W)
    ) u_root_ti (
        .i_clk  (i_clk),
        .i_load (w_root_load),
        .i_step (w_root_step),
        .i_v    (V_W'({w_d2_ti, 8'h00})),
        .o_root (w_root_ti)
    );

    lsd_isqrt #(
        .V_W (V_W)
    ) u_root_tp (
        .i_clk  (i_clk),
        .i_load (w_root_load),
        .i_step (w_root_step),
        .i_v    (V_W'({w_d2_tp, 8'h00})),
        .o_root (w_root_tp)
    );

    // sequencer, history and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_hist      <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_avg_x     <= '0;
            r_avg_y     <= '0;
            r_dead      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in hand-off the result register is reloaded below
            if (r_out_valid && !i_out_stall && (r_state != ST_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept) begin
                        if (i_action == lsd_pkg::ACT_CLEAR) begin
                            r_hist   <= 1'b0;
                            r_last_x <= '0;
                            r_last_y <= '0;
                            r_avg_x  <= '0;
                            r_avg_y  <= '0;
                        end else begin
                            r_state <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE: begin
                    if (r_cnt == lsd_pkg::SCALE_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_MUL: begin
                    if (r_cnt == lsd_pkg::MUL_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_ROOT: begin
                    if (r_cnt == '0) begin
                        // products are final here: commit history
                        r_dead   <= r_hist && w_small_move;
                        if (r_hist) begin
                            r_avg_x <= w_new_x[AW-1:0];
                            r_avg_y <= w_new_y[AW-1:0];
                        end else begin
                            r_avg_x <= {w_pix[4], 8'h00};
                            r_avg_y <= {w_pix[5], 8'h00};
                        end
                        r_last_x <= w_pix[4];
                        r_last_y <= w_pix[5];
                        r_hist   <= 1'b1;
                    end
                    if (r_cnt == lsd_pkg::ROOT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_HOLD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_gap_ti    <= w_root_ti[lsd_pkg::GAP_W-1:0];
                        r_gap_tp    <= w_root_tp[lsd_pkg::GAP_W-1:0];
                        r_out_dead  <= r_dead;
                        r_out_x     <= r_avg_x;
                        r_out_y     <= r_avg_y;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_thumb_index_gap = r_gap_ti;
    assign o_thumb_pinky_gap = r_gap_tp;
    assign o_in_dead_zone    = r_out_dead;
    assign o_filtered_x      = r_out_x;
    assign o_filtered_y      = r_out_y;

endmodule
